FILE: hdl/md5_pkg.sv
// Shared types, constants, round tables and control store for the MD5 digest unit.
`default_nettype none
package md5_pkg;

  localparam int unsigned PC_W = 4;

  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_LOAD  = 4'd1;
  localparam logic [PC_W-1:0] PC_ROUND = 4'd2;
  localparam logic [PC_W-1:0] PC_FOLD  = 4'd3;
  localparam logic [PC_W-1:0] PC_CHECK = 4'd4;
  localparam logic [PC_W-1:0] PC_PAD   = 4'd5;
  localparam logic [PC_W-1:0] PC_ZERO  = 4'd6;
  localparam logic [PC_W-1:0] PC_LEN   = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT0 = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT1 = 4'd9;

  localparam logic [1:0] MODE_DATA = 2'd0;
  localparam logic [1:0] MODE_LAST = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic [1:0] mode;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_half;
    logic        last_half;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ROUND,
    OP_FOLD,
    OP_NOP,
    OP_PAD,
    OP_ZERO,
    OP_LEN,
    OP_EMIT0,
    OP_EMIT1
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_BLOCK_FULL,
    C_END_NOW,
    C_ROUND_LAST,
    C_NOT_FIN,
    C_DONE,
    C_PADDED,
    C_ZERO_STOP,
    C_PTR_LAST,
    C_OUT_TAKEN
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond_a;
    logic [PC_W-1:0] tgt_a;
    cond_t           cond_b;
    logic [PC_W-1:0] tgt_b;
    logic            hold;
  } ucode_t;

  typedef struct packed {
    logic ptr_last;
    logic zero_stop;
    logic round_last;
    logic fin;
    logic done;
    logic padded;
  } status_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    case (pc)
      PC_IDLE:  uc = '{OP_IDLE,  C_BLOCK_FULL, PC_LOAD,  C_END_NOW,   PC_PAD,  1'b1};
      PC_LOAD:  uc = '{OP_LOAD,  C_NEVER,      PC_IDLE,  C_NEVER,     PC_IDLE, 1'b0};
      PC_ROUND: uc = '{OP_ROUND, C_ROUND_LAST, PC_FOLD,  C_NEVER,     PC_IDLE, 1'b1};
      PC_FOLD:  uc = '{OP_FOLD,  C_NOT_FIN,    PC_IDLE,  C_DONE,      PC_EMIT0, 1'b0};
      PC_CHECK: uc = '{OP_NOP,   C_PADDED,     PC_ZERO,  C_NEVER,     PC_IDLE, 1'b0};
      PC_PAD:   uc = '{OP_PAD,   C_PTR_LAST,   PC_LOAD,  C_NEVER,     PC_IDLE, 1'b0};
      PC_ZERO:  uc = '{OP_ZERO,  C_ZERO_STOP,  PC_LEN,   C_PTR_LAST,  PC_LOAD, 1'b1};
      PC_LEN:   uc = '{OP_LEN,   C_PTR_LAST,   PC_LOAD,  C_NEVER,     PC_IDLE, 1'b1};
      PC_EMIT0: uc = '{OP_EMIT0, C_OUT_TAKEN,  PC_EMIT1, C_NEVER,     PC_IDLE, 1'b1};
      PC_EMIT1: uc = '{OP_EMIT1, C_OUT_TAKEN,  PC_IDLE,  C_NEVER,     PC_IDLE, 1'b1};
      default:  uc = '{OP_NOP,   C_ALWAYS,     PC_IDLE,  C_NEVER,     PC_IDLE, 1'b0};
    endcase
    return uc;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
      2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
      2'd3:    idx = 4'(lo * 4'd7);
      default: idx = lo;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      4'd15:   s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'hd76aa478;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/md5_message_digest_unit.sv
// Top level of the MD5 digest unit: sequencer, datapath and port handshakes.
//
//   channel  direction  word        handshake
//   in_      input      in_word_t   in_valid / in_stall
//   out_     output     out_word_t  out_valid / out_stall
//
// A data byte that does not fill the block is written into the block buffer at the current pointer.
// A full block then goes through load, 64 rounds (one per cycle) and fold.
// End of message writes padding and length one byte a cycle, compresses one or
// two blocks, then presents two digest words; the round loop sets the rate.
// Reset is synchronous; in_stall stays high from an accepted end until the
// second digest word is taken, and out_stall holds the current digest word.
`default_nettype none
module md5_message_digest_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire md5_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output md5_pkg::out_word_t      out_word
);

  md5_pkg::op_t     op;
  md5_pkg::status_t stat;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  md5_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_mode   (in_word.mode),
    .out_acc   (out_acc),
    .stat      (stat),
    .op        (op),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  md5_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_acc   (in_acc),
    .in_word  (in_word),
    .out_acc  (out_acc),
    .stat     (stat),
    .out_word (out_word)
  );

  a_no_out_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("digest word offered while input is open");

  a_second_follows_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_word.last_half) |=> (out_valid && out_word.last_half))
    else $error("second digest word missing after first");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_word.last_half) |=> (!in_stall && !out_valid))
    else $error("unit not idle after final digest word");

endmodule
`default_nettype wire

FILE: hdl/md5_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module md5_sequencer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_acc,
  input  wire logic [1:0]       in_mode,
  input  wire logic             out_acc,
  input  wire md5_pkg::status_t stat,
  output md5_pkg::op_t          op,
  output logic                  in_stall,
  output logic                  out_valid
);

  logic [md5_pkg::PC_W-1:0] pc_r;
  logic [md5_pkg::PC_W-1:0] pc_nxt;
  md5_pkg::ucode_t          uc;
  logic                     hit_a;
  logic                     hit_b;
  logic                     data_mode;
  logic                     end_mode;

  function automatic logic cond_eval(input md5_pkg::cond_t c, input md5_pkg::status_t s,
                                     input logic acc, input logic dmode, input logic emode,
                                     input logic oacc);
    logic v;
    case (c)
      md5_pkg::C_NEVER:      v = 1'b0;
      md5_pkg::C_ALWAYS:     v = 1'b1;
      md5_pkg::C_BLOCK_FULL: v = acc && dmode && s.ptr_last;
      md5_pkg::C_END_NOW:    v = acc && emode;
      md5_pkg::C_ROUND_LAST: v = s.round_last;
      md5_pkg::C_NOT_FIN:    v = !s.fin;
      md5_pkg::C_DONE:       v = s.done;
      md5_pkg::C_PADDED:     v = s.padded;
      md5_pkg::C_ZERO_STOP:  v = s.zero_stop;
      md5_pkg::C_PTR_LAST:   v = s.ptr_last;
      md5_pkg::C_OUT_TAKEN:  v = oacc;
      default:               v = 1'b0;
    endcase
    return v;
  endfunction

  assign uc        = md5_pkg::ucode_rom(pc_r);
  assign data_mode = (in_mode == md5_pkg::MODE_DATA) || (in_mode == md5_pkg::MODE_LAST);
  assign end_mode  = (in_mode == md5_pkg::MODE_LAST) || (in_mode == md5_pkg::MODE_END);
  assign hit_a     = cond_eval(uc.cond_a, stat, in_acc, data_mode, end_mode, out_acc);
  assign hit_b     = cond_eval(uc.cond_b, stat, in_acc, data_mode, end_mode, out_acc);

  always_comb begin
    if (hit_a) begin
      pc_nxt = uc.tgt_a;
    end else if (hit_b) begin
      pc_nxt = uc.tgt_b;
    end else if (uc.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = md5_pkg::PC_W'(pc_r + 1'b1);
    end
  end

  always_comb begin
    op        = uc.op;
    in_stall  = (uc.op != md5_pkg::OP_IDLE);
    out_valid = (uc.op == md5_pkg::OP_EMIT0) || (uc.op == md5_pkg::OP_EMIT1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= md5_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/md5_datapath.sv
// Datapath: block buffer memory, chaining words, round registers, counters and digest output.
`default_nettype none
module md5_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire md5_pkg::op_t      op,
  input  wire logic              in_acc,
  input  wire md5_pkg::in_word_t in_word,
  input  wire logic              out_acc,
  output md5_pkg::status_t       stat,
  output md5_pkg::out_word_t     out_word
);

  logic [7:0]        blk_mem [4][16];
  logic [31:0]       w_rd_r;
  logic [3:0]        raddr;
  logic              we;
  logic [7:0]        wbyte;

  logic [3:0][31:0]  h_r;
  logic [3:0][31:0]  h_nxt;
  logic [31:0]       a_r, b_r, c_r, d_r;
  logic [31:0]       a_nxt, b_nxt, c_nxt, d_nxt;
  logic [5:0]        rnd_r, rnd_nxt;
  logic [5:0]        ptr_r, ptr_nxt;
  logic [63:0]       cnt_r, cnt_nxt;
  logic              fin_r, fin_nxt;
  logic              padded_r, padded_nxt;
  logic              done_r, done_nxt;
  logic              wrap_r, wrap_nxt;

  logic [31:0]       f;
  logic [31:0]       t;
  logic [63:0]       rot_dbl;
  logic [31:0]       b_new;
  logic              zero_stop;
  logic              in_data;
  logic              in_end;
  logic [5:0]        ptr_inc;

  assign zero_stop = (ptr_r == md5_pkg::LEN_POS) && !wrap_r;
  assign in_data   = (in_word.mode == md5_pkg::MODE_DATA) ||
                     (in_word.mode == md5_pkg::MODE_LAST);
  assign in_end    = (in_word.mode == md5_pkg::MODE_LAST) ||
                     (in_word.mode == md5_pkg::MODE_END);
  assign ptr_inc   = 6'(ptr_r + 6'd1);

  always_comb begin
    stat.ptr_last   = (ptr_r == md5_pkg::LAST_POS);
    stat.zero_stop  = zero_stop;
    stat.round_last = (rnd_r == md5_pkg::LAST_RND);
    stat.fin        = fin_r;
    stat.done       = done_r;
    stat.padded     = padded_r;
  end

  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      2'd3:    f = c_r ^ (b_r | ~d_r);
      default: f = b_r ^ c_r ^ d_r;
    endcase
    t       = a_r + f + w_rd_r + md5_pkg::round_k(rnd_r);
    rot_dbl = {t, t} << md5_pkg::rot_amt(rnd_r);
    b_new   = rot_dbl[63:32] + b_r;
  end

  always_comb begin
    if (op == md5_pkg::OP_LOAD) begin
      raddr = md5_pkg::msg_index(6'd0);
    end else begin
      raddr = md5_pkg::msg_index(6'(rnd_r + 6'd1));
    end
  end

  always_comb begin
    we    = 1'b0;
    wbyte = in_word.msg_byte;
    case (op)
      md5_pkg::OP_IDLE: begin
        we    = in_acc && in_data;
        wbyte = in_word.msg_byte;
      end
      md5_pkg::OP_PAD: begin
        we    = 1'b1;
        wbyte = md5_pkg::PAD_BYTE;
      end
      md5_pkg::OP_ZERO: begin
        we    = !zero_stop;
        wbyte = 8'd0;
      end
      md5_pkg::OP_LEN: begin
        we    = 1'b1;
        wbyte = cnt_r[{ptr_r[2:0], 3'b000} +: 8];
      end
      default: begin
        we    = 1'b0;
        wbyte = in_word.msg_byte;
      end
    endcase
  end

  always_comb begin
    h_nxt      = h_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    rnd_nxt    = rnd_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    padded_nxt = padded_r;
    done_nxt   = done_r;
    wrap_nxt   = wrap_r;
    case (op)
      md5_pkg::OP_IDLE: begin
        if (in_acc && in_data) begin
          ptr_nxt = ptr_inc;
          cnt_nxt = cnt_r + 64'd8;
        end
        if (in_acc && in_end) begin
          fin_nxt = 1'b1;
        end
      end
      md5_pkg::OP_LOAD: begin
        a_nxt   = h_r[0];
        b_nxt   = h_r[1];
        c_nxt   = h_r[2];
        d_nxt   = h_r[3];
        rnd_nxt = 6'd0;
      end
      md5_pkg::OP_ROUND: begin
        a_nxt   = d_r;
        b_nxt   = b_new;
        c_nxt   = b_r;
        d_nxt   = c_r;
        rnd_nxt = 6'(rnd_r + 6'd1);
      end
      md5_pkg::OP_FOLD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
      end
      md5_pkg::OP_PAD: begin
        ptr_nxt    = ptr_inc;
        padded_nxt = 1'b1;
        wrap_nxt   = (ptr_r >= md5_pkg::LEN_POS) && (ptr_r != md5_pkg::LAST_POS);
      end
      md5_pkg::OP_ZERO: begin
        if (!zero_stop) begin
          ptr_nxt = ptr_inc;
          if (ptr_r == md5_pkg::LAST_POS) begin
            wrap_nxt = 1'b0;
          end
        end
      end
      md5_pkg::OP_LEN: begin
        ptr_nxt = ptr_inc;
        if (ptr_r == md5_pkg::LAST_POS) begin
          done_nxt = 1'b1;
        end
      end
      md5_pkg::OP_EMIT1: begin
        if (out_acc) begin
          h_nxt      = {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
          ptr_nxt    = 6'd0;
          cnt_nxt    = 64'd0;
          fin_nxt    = 1'b0;
          padded_nxt = 1'b0;
          done_nxt   = 1'b0;
          wrap_nxt   = 1'b0;
        end
      end
      default: begin
        h_nxt = h_r;
      end
    endcase
  end

  always_comb begin
    if (op == md5_pkg::OP_EMIT1) begin
      out_word.digest_half = {md5_pkg::bswap32(h_r[2]), md5_pkg::bswap32(h_r[3])};
      out_word.last_half   = 1'b1;
    end else begin
      out_word.digest_half = {md5_pkg::bswap32(h_r[0]), md5_pkg::bswap32(h_r[1])};
      out_word.last_half   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      blk_mem[ptr_r[1:0]][ptr_r[5:2]] <= wbyte;
    end
    w_rd_r <= {blk_mem[3][raddr], blk_mem[2][raddr], blk_mem[1][raddr], blk_mem[0][raddr]};
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r      <= {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
      rnd_r    <= 6'd0;
      ptr_r    <= 6'd0;
      cnt_r    <= 64'd0;
      fin_r    <= 1'b0;
      padded_r <= 1'b0;
      done_r   <= 1'b0;
      wrap_r   <= 1'b0;
    end else begin
      h_r      <= h_nxt;
      rnd_r    <= rnd_nxt;
      ptr_r    <= ptr_nxt;
      cnt_r    <= cnt_nxt;
      fin_r    <= fin_nxt;
      padded_r <= padded_nxt;
      done_r   <= done_nxt;
      wrap_r   <= wrap_nxt;
    end
  end

endmodule
`default_nettype wire
